### rtl/sha_pkg.sv
// sha-256 package: beat types, round constants, initial hash words and round functions
// used by the sha-256 message digest unit top level, no dependencies
`default_nettype none
package sha_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       message_end;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        final_word;
	} out_beat_t;

	// round constant table
	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		case (t)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		logic [31:0] v;
		case (i)
			3'd0: v = 32'h6a09e667; 3'd1: v = 32'hbb67ae85;
			3'd2: v = 32'h3c6ef372; 3'd3: v = 32'ha54ff53a;
			3'd4: v = 32'h510e527f; 3'd5: v = 32'h9b05688c;
			3'd6: v = 32'h1f83d9ab; default: v = 32'h5be0cd19;
		endcase
		return v;
	endfunction

	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage
`default_nettype wire

### rtl/sha_sched_ram.sv
// sha-256 schedule memory: 16 words, one write port, four read ports, registered reads
// depends on nothing
`default_nettype none
module sha_sched_ram (
	input  wire logic        clk,
	input  wire logic        we,
	input  wire logic [3:0]  waddr,
	input  wire logic [31:0] wdata,
	input  wire logic [3:0]  raddr_a,
	input  wire logic [3:0]  raddr_b,
	input  wire logic [3:0]  raddr_c,
	input  wire logic [3:0]  raddr_d,
	output logic [31:0]      rdata_a,
	output logic [31:0]      rdata_b,
	output logic [31:0]      rdata_c,
	output logic [31:0]      rdata_d
);
	logic [31:0] mem [16];

	// write and registered reads
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
		rdata_c <= mem[raddr_c];
		rdata_d <= mem[raddr_d];
	end
endmodule
`default_nettype wire

### rtl/sha256_message_digest_unit.sv
// sha-256 message digest unit top level: byte packing, padding, round engine, digest output
// depends on sha_pkg and sha_sched_ram
`default_nettype none
// Message bytes enter one beat per cycle while the unit is reading. Each 64th byte
// starts a compression that holds off input: a setup state, 64 rounds and a final
// add into the hash. An end beat pads the block one byte per cycle (up to 64 fill
// bytes in all), writes the length as two words, high then low, runs one or two
// compressions, then gives eight digest beats at the pace of out_ready; no input
// beat is taken until the eighth digest beat is. The 16-word schedule lives in a
// small memory whose registered reads are addressed in the cycle before each round,
// so the round loop sets the block rate.
module sha256_message_digest_unit
	import sha_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_beat_t  in_data,
	input  wire logic      in_valid,
	output logic           in_ready,
	output out_beat_t      out_data,
	output logic           out_valid,
	input  wire logic      out_ready
);
	localparam logic [2:0] ST_READ  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_LEN   = 3'd2;
	localparam logic [2:0] ST_PRE   = 3'd3;
	localparam logic [2:0] ST_ROUND = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]   state_q;
	logic [63:0]  bitlen_q;
	logic [5:0]   bcnt_q;
	logic [31:0]  wacc_q;
	logic         ending_q;   // compression belongs to the padded tail
	logic         lenblk_q;   // next pad byte is the 0x80 mark
	logic [6:0]   round_q;
	logic [31:0]  hash_q [8];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [2:0]   oidx_q;
	logic         len_lo_q;

	// schedule memory ports
	logic         we;
	logic [3:0]   waddr, ra, rb, rc, rd;
	logic [31:0]  wdata, rda, rdb, rdc, rdd;

	sha_sched_ram u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr_a(ra), .raddr_b(rb), .raddr_c(rc), .raddr_d(rd),
		.rdata_a(rda), .rdata_b(rdb), .rdata_c(rdc), .rdata_d(rdd)
	);

	// byte packing
	logic        take;
	logic [7:0]  pbyte;
	logic        pstep;
	logic [31:0] wnext;
	assign in_ready = (state_q == ST_READ);
	assign take = in_valid && in_ready;
	always_comb begin
		pbyte = 8'h00;
		pstep = 1'b0;
		if (take && in_data.byte_valid) begin
			pbyte = in_data.data_byte;
			pstep = 1'b1;
		end else if (state_q == ST_PAD) begin
			pbyte = lenblk_q ? PAD_BYTE : 8'h00;
			pstep = 1'b1;
		end
		case (bcnt_q[1:0])
			2'd0: wnext = {pbyte, 24'h0};
			2'd1: wnext = {wacc_q[31:24], pbyte, 16'h0};
			2'd2: wnext = {wacc_q[31:16], pbyte, 8'h0};
			default: wnext = {wacc_q[31:8], pbyte};
		endcase
	end

	// round datapath; words for round t read in the cycle before
	// port a: word t-2, port b: word t-7, port c: word t-16, port d: word t-15
	logic [5:0]  t;
	logic [31:0] wt, t1, t2;
	assign t = round_q[5:0];
	always_comb begin
		wt = (t >= 6'd16) ? (ssig1(rda) + rdb + ssig0(rdd) + rdc) : rdc;
		t1 = h_q + bsig1(e_q) + ((e_q & f_q) ^ (~e_q & g_q)) + round_k(t) + wt;
		t2 = bsig0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	end

	// memory addressing; a round writes entry t and reads t-1, t-6, t+1, t+2,
	// and word t-1 was written in the round before, so no access needs forwarding
	always_comb begin
		we = 1'b0; waddr = bcnt_q[5:2]; wdata = wnext;
		ra = 4'd0; rb = 4'd0; rc = 4'd0; rd = 4'd0;
		if (pstep && (state_q == ST_READ || state_q == ST_PAD) &&
			bcnt_q[1:0] == 2'd3) we = 1'b1;
		if (state_q == ST_LEN) begin
			we = 1'b1; waddr = len_lo_q ? 4'd15 : 4'd14;
			wdata = len_lo_q ? bitlen_q[31:0] : bitlen_q[63:32];
		end
		if (state_q == ST_PRE) begin
			ra = 4'd14; rb = 4'd9; rc = 4'd0; rd = 4'd1;
		end
		if (state_q == ST_ROUND) begin
			we = (t >= 6'd16); waddr = t[3:0]; wdata = wt;
			ra = 4'(t + 6'd15); rb = 4'(t + 6'd10);
			rc = 4'(t + 6'd1); rd = 4'(t + 6'd2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_READ;
			bitlen_q <= '0;
			bcnt_q   <= '0;
			ending_q <= 1'b0;
			lenblk_q <= 1'b0;
			round_q  <= '0;
			oidx_q   <= '0;
			len_lo_q <= 1'b0;
			for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
		end else begin
			case (state_q)
				ST_READ: begin
					if (take) begin
						if (in_data.byte_valid) begin
							bitlen_q <= bitlen_q + 64'd8;
							bcnt_q   <= bcnt_q + 6'd1;
							if (bcnt_q == 6'd63) state_q <= ST_PRE;
						end
						if (in_data.message_end) begin
							ending_q <= 1'b1;
							lenblk_q <= 1'b1; // next pad byte is 0x80
							if (!(in_data.byte_valid && bcnt_q == 6'd63)) state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					lenblk_q <= 1'b0;
					bcnt_q <= bcnt_q + 6'd1;
					if (bcnt_q == 6'd63) state_q <= ST_PRE;
					else if (bcnt_q == 6'd55) begin
						state_q <= ST_LEN; len_lo_q <= 1'b0;
					end
				end
				ST_LEN: begin
					len_lo_q <= 1'b1;
					if (len_lo_q) begin
						bcnt_q <= 6'd0; state_q <= ST_PRE; len_lo_q <= 1'b0;
						ending_q <= 1'b0; oidx_q <= 3'd1; // mark final block
					end
				end
				ST_PRE: begin
					round_q <= '0; state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					round_q <= round_q + 7'd1;
					if (t == 6'd63) state_q <= ST_FIN;
				end
				ST_FIN: begin
					hash_q[0] <= hash_q[0] + a_q; hash_q[1] <= hash_q[1] + b_q;
					hash_q[2] <= hash_q[2] + c_q; hash_q[3] <= hash_q[3] + d_q;
					hash_q[4] <= hash_q[4] + e_q; hash_q[5] <= hash_q[5] + f_q;
					hash_q[6] <= hash_q[6] + g_q; hash_q[7] <= hash_q[7] + h_q;
					round_q <= '0;
					if (oidx_q == 3'd1) begin
						state_q <= ST_OUT; oidx_q <= 3'd0;
					end else if (ending_q) state_q <= ST_PAD;
					else state_q <= ST_READ;
				end
				ST_OUT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= ST_READ;
							bitlen_q <= '0;
							bcnt_q <= '0;
							for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
						end
					end
				end
				default: state_q <= ST_READ;
			endcase
		end
	end

	// payload registers: word accumulator and working variables
	always_ff @(posedge clk) begin
		if (pstep && (state_q == ST_READ || state_q == ST_PAD)) wacc_q <= wnext;
		if (state_q == ST_PRE) begin
			a_q <= hash_q[0]; b_q <= hash_q[1]; c_q <= hash_q[2]; d_q <= hash_q[3];
			e_q <= hash_q[4]; f_q <= hash_q[5]; g_q <= hash_q[6]; h_q <= hash_q[7];
		end
		if (state_q == ST_ROUND) begin
			h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
	end

	assign out_valid = (state_q == ST_OUT);
	assign out_data.digest_word = hash_q[oidx_q];
	assign out_data.word_index = oidx_q;
	assign out_data.final_word = (oidx_q == 3'd7);
endmodule
`default_nettype wire
